FILE: src/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants of the move-to-front list
// Holds the list size, element width, command and status codes and the
// control word that the top level broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // port field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_END       = 3'd4,
    ST_REWOUND   = 3'd5
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    elem_t            key;
    logic [CNT_W-1:0] count;
    logic             wr_add;   // append key at position count
    logic             wr_get;   // move the matching entry to the front
  } cell_ctrl_t;

endpackage

FILE: src/mtf_cell.sv
// ----------------------------------------------------------------------------
// mtf_cell: one position of the move-to-front list
// Holds one element, compares it with the key and takes its left
// neighbor's element when a hit at or behind it moves an entry forward.
// ----------------------------------------------------------------------------
module mtf_cell (
  input  logic                    clk,
  input  logic [mtf_pkg::IDX_W-1:0] idx,
  input  mtf_pkg::cell_ctrl_t     ctrl,
  input  mtf_pkg::elem_t          prev_value,
  input  logic                    chain_in,
  output logic                    chain_out,
  output logic                    match,
  output mtf_pkg::elem_t          value
);
  import mtf_pkg::*;

  logic valid;

  assign valid     = CNT_W'(idx) < ctrl.count;
  assign match     = valid && (value == ctrl.key);
  // high when the hit sits at this position or further back
  assign chain_out = chain_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.wr_get && chain_out) begin
      value <= prev_value;
    end else if (ctrl.wr_add && (CNT_W'(idx) == ctrl.count)) begin
      value <= ctrl.key;
    end
  end

endmodule

FILE: src/mtf_list.sv
// ----------------------------------------------------------------------------
// mtf_list: row of list cells
// Chains the cells so that hits propagate toward the head and elements
// shift back one place, and selects the element under the read cursor.
// ----------------------------------------------------------------------------
module mtf_list (
  input  logic                      clk,
  input  logic                      rst,
  input  mtf_pkg::cell_ctrl_t       ctrl,
  input  logic [mtf_pkg::IDX_W-1:0] rd_idx,
  output logic                      present,
  output mtf_pkg::elem_t            rd_value
);
  import mtf_pkg::*;

  elem_t               values [CAPACITY];
  logic [CAPACITY:0]   chain;
  logic [CAPACITY-1:0] match;

  assign chain[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t prev;
    if (i == 0) begin : g_head
      // the head takes the key itself on a move to front
      assign prev = ctrl.key;
    end else begin : g_body
      assign prev = values[i-1];
    end
    mtf_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .prev_value (prev),
      .chain_in   (chain[i+1]),
      .chain_out  (chain[i]),
      .match      (match[i]),
      .value      (values[i])
    );
  end

  assign present  = chain[0];
  assign rd_value = values[rd_idx];

  // add never inserts a duplicate, so a key matches at most one cell
  a_distinct: assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("mtf_list: key matches more than one entry");

endmodule

FILE: src/move_to_front_list_top.sv
// ----------------------------------------------------------------------------
// move_to_front_list_top: move-to-front list
// Ordered list of distinct elements with add, get with move to front, and a
// read cursor; one result word per command word.
// ----------------------------------------------------------------------------
// Each command runs in two states: the word is registered in S_IDLE, and in
// S_EXEC every cell compares its element with the key at once, the hit
// propagates along the cell chain toward the head, the list updates and the
// result is loaded into the output register. A new word is taken right after
// that, while the result may still wait; a result held by the sink keeps the
// block in S_EXEC until the output register frees. No setup after reset.
module move_to_front_list_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mtf_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] element_value
  input  logic [mtf_pkg::CMD_W-1:0]       s_tuser,   // [1:0] command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mtf_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] read_value, [36:32] element_count
  output logic [mtf_pkg::STATUS_W-1:0]    m_tuser    // [2:0] status
);
  import mtf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t           state, state_next;
  cmd_t             cmd;
  elem_t            key;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] cursor, cursor_next;
  status_t          status, status_next;
  elem_t            rd, rd_next;
  logic [CNT_W-1:0] out_count;

  cell_ctrl_t       ctrl;
  logic             present;
  elem_t            cur_value;
  logic             out_free;
  logic             commit;
  logic             full;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_EXEC) && out_free;
  assign full     = (count >= CNT_W'(CAPACITY));

  assign ctrl.key    = key;
  assign ctrl.count  = count;
  assign ctrl.wr_add = commit && (cmd == CMD_ADD) && !present && !full;
  assign ctrl.wr_get = commit && (cmd == CMD_GET) && present;

  mtf_list u_list (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_idx   (cursor[IDX_W-1:0]),
    .present  (present),
    .rd_value (cur_value)
  );

  always_comb begin
    status_next = ST_OK;
    rd_next     = '0;
    count_next  = count;
    cursor_next = cursor;
    unique case (cmd)
      CMD_ADD: begin
        if (present) begin
          status_next = ST_PRESENT;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (present) begin
          rd_next = key;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      CMD_REWIND: begin
        cursor_next = '0;
        status_next = ST_REWOUND;
      end
      CMD_NEXT: begin
        if (cursor < count) begin
          rd_next     = cur_value;
          cursor_next = cursor + CNT_W'(1);
        end else begin
          status_next = ST_END;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count    <= count_next;
        cursor   <= cursor_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_t'(s_tuser);
      key <= ELEM_W'(s_tdata[VALUE_W-1:0]);
    end
    if (commit) begin
      status    <= status_next;
      rd        <= rd_next;
      out_count <= count_next;
    end
  end

  assign m_tuser = status;
  assign m_tdata = {{(OUT_DATA_W - VALUE_W - COUNT_W){1'b0}},
                    COUNT_W'(out_count), VALUE_W'(rd)};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("read cursor past the end of the list");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC) && !s_tready)
    else $error("accepted word not executed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CNT_W'(1)))
    else $error("count changed other than by one append");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the move-to-front list
// Drives command words on the input stream and keeps its own copy of the
// list, its fill level and its read cursor. From that copy it predicts the
// status, read value and element count of every result word. It opens with
// short directed cases on an empty and a small list, then runs random
// sequences: cursor walks, mixed commands and add bursts. Both sides idle in
// short random bursts, except near the end.
// ----------------------------------------------------------------------------

typedef struct packed {
  mtf_pkg::status_t          status;
  mtf_pkg::elem_t            read_value;
  logic [mtf_pkg::COUNT_W-1:0] count;
} list_result_t;

class list_scoreboard;
  mtf_pkg::elem_t entries[mtf_pkg::CAPACITY];
  int unsigned    fill;
  int unsigned    cursor;
  list_result_t   expected_results[$];
  int unsigned    mismatches;
  int unsigned    checked;
  int unsigned    full_refusals;
  int unsigned    moves;
  int unsigned    cmd_seen[4];

  function void report(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  // update the shadow list for one accepted command word and queue its result
  function void note_command(mtf_pkg::cmd_t cmd, mtf_pkg::elem_t value);
    list_result_t r;
    int pos;
    r.status     = mtf_pkg::ST_OK;
    r.read_value = '0;
    pos = -1;
    cmd_seen[cmd]++;
    if (cmd == mtf_pkg::CMD_ADD || cmd == mtf_pkg::CMD_GET) begin
      for (int i = 0; i < int'(fill); i++)
        if (pos < 0 && entries[i] == value) pos = i;
    end
    case (cmd)
      mtf_pkg::CMD_ADD: begin
        // presence is tested before fullness
        if (pos >= 0) begin
          r.status = mtf_pkg::ST_PRESENT;
        end else if (fill >= mtf_pkg::CAPACITY) begin
          r.status = mtf_pkg::ST_FULL;
          full_refusals++;
        end else begin
          entries[fill] = value;
          fill++;
        end
      end
      mtf_pkg::CMD_GET: begin
        if (pos < 0) begin
          r.status = mtf_pkg::ST_NOT_FOUND;
        end else begin
          if (pos > 0) moves++;
          for (int i = pos; i > 0; i--) entries[i] = entries[i-1];
          entries[0]   = value;
          r.read_value = value;
        end
      end
      mtf_pkg::CMD_REWIND: begin
        cursor   = 0;
        r.status = mtf_pkg::ST_REWOUND;
      end
      default: begin
        // cursor is a plain position, reordering does not move it
        if (cursor < fill) begin
          r.read_value = entries[cursor];
          cursor++;
        end else begin
          r.status = mtf_pkg::ST_END;
        end
      end
    endcase
    r.count = fill[mtf_pkg::COUNT_W-1:0];
    expected_results.push_back(r);
  endfunction

  function void check_result(logic [mtf_pkg::STATUS_W-1:0] status,
                             logic [mtf_pkg::VALUE_W-1:0] read_value,
                             logic [mtf_pkg::COUNT_W-1:0] count);
    list_result_t e;
    if (expected_results.size() == 0) begin
      report($sformatf("result with nothing pending: status %0d value %h count %0d",
                       status, read_value, count));
      return;
    end
    e = expected_results.pop_front();
    checked++;
    if (status !== e.status || read_value !== e.read_value || count !== e.count)
      report($sformatf("expected status %0d value %h count %0d, got status %0d value %h count %0d",
                       e.status, e.read_value, e.count, status, read_value, count));
  endfunction
endclass

module testbench;
  import mtf_pkg::*;

  localparam int unsigned ITEMS      = 1350;
  localparam int unsigned CALM_ITEMS = 200;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [31:0] element_value
  logic [CMD_W-1:0]      s_tuser;   // [1:0] command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [31:0] read_value, [36:32] element_count
  logic [STATUS_W-1:0]   m_tuser;   // [2:0] status

  list_scoreboard sb = new();
  bit             idle_on;
  int unsigned    stall_left;
  int unsigned    items;

  move_to_front_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // sink stalls in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_command(cmd_t'(s_tuser), s_tdata[VALUE_W-1:0]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: COUNT_W]);
    end
  end

  task automatic send(cmd_t cmd, elem_t value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    items++;
  endtask

  // hold the input until every pending result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  function automatic elem_t member_or_random(int unsigned member_pct);
    if (sb.fill != 0 && $urandom_range(0, 99) < member_pct)
      return sb.entries[$urandom_range(0, sb.fill - 1)];
    return $urandom;
  endfunction

  task automatic random_command();
    cmd_t        cmd;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25)      cmd = CMD_ADD;
    else if (r < 60) cmd = CMD_GET;
    else if (r < 70) cmd = CMD_REWIND;
    else             cmd = CMD_NEXT;
    case (cmd)
      CMD_ADD: send(cmd, member_or_random(40));
      CMD_GET: send(cmd, member_or_random(75));
      default: send(cmd, $urandom);
    endcase
  endtask

  initial begin
    int unsigned kind;
    int unsigned walk_len;
    int unsigned next_drain;
    int unsigned wait_cycles;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_REWIND;
    m_tready <= 1'b0;
    idle_on  <= 1'b1;
    stall_left = 0;
    items      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty list, then a short list of extreme values
    send(CMD_NEXT,   $urandom);
    send(CMD_GET,    32'h0000_0000);
    send(CMD_REWIND, $urandom);
    send(CMD_ADD,    32'h0000_0000);
    send(CMD_ADD,    32'hFFFF_FFFF);
    send(CMD_ADD,    32'h0000_0000);
    send(CMD_ADD,    32'h8000_0001);
    send(CMD_ADD,    32'h7FFF_FFFE);
    send(CMD_GET,    32'h0000_0000);
    send(CMD_GET,    32'h7FFF_FFFE);
    send(CMD_GET,    32'h1234_5678);
    send(CMD_REWIND, $urandom);
    send(CMD_NEXT,   $urandom);
    send(CMD_NEXT,   $urandom);
    // reorder under the cursor
    send(CMD_GET,    32'hFFFF_FFFF);
    send(CMD_NEXT,   $urandom);
    send(CMD_NEXT,   $urandom);
    send(CMD_NEXT,   $urandom);
    send(CMD_NEXT,   $urandom);
    send(CMD_GET,    32'h8000_0001);
    drain();

    next_drain = items + 300;
    while (items < ITEMS) begin
      idle_on <= (items + CALM_ITEMS < ITEMS) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // cursor walk of up to two steps beyond the fill level, with a few gets mixed in
        send(CMD_REWIND, $urandom);
        walk_len = sb.fill + $urandom_range(0, 2);
        repeat (walk_len) begin
          if ($urandom_range(0, 5) == 0) send(CMD_GET, member_or_random(90));
          else                           send(CMD_NEXT, $urandom);
        end
      end else if (kind < 8) begin
        repeat (8) random_command();
      end else begin
        repeat (4) send(CMD_ADD, member_or_random(30));
      end
      if (items >= next_drain) begin
        drain();
        next_drain = items + 300;
      end
    end

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.expected_results.size() != 0) begin
      @(posedge clk);
      wait_cycles++;
      if (wait_cycles > 5000) begin
        $display("Mismatches found");
        $finish;
      end
    end
    repeat (8) @(posedge clk);

    $display("commands sent: %0d add, %0d get, %0d rewind, %0d next",
             sb.cmd_seen[CMD_ADD], sb.cmd_seen[CMD_GET],
             sb.cmd_seen[CMD_REWIND], sb.cmd_seen[CMD_NEXT]);
    $display("%0d results checked, %0d moves to front, %0d adds refused on a full list",
             sb.checked, sb.moves, sb.full_refusals);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: move_to_front_list_top.f
src/mtf_pkg.sv
src/mtf_cell.sv
src/mtf_list.sv
src/move_to_front_list_top.sv
tb/sv/testbench.sv
